// ----- rtl/drrl_pkg.sv -----
// drrl_pkg: shared types, constants and helpers for the ring record logger.
// Depends on nothing; every other file of the block but drrl_checks imports it.
`default_nettype none

package drrl_pkg;

  // Default store depth and record geometry
  localparam int SLOTS_DEF    = 64;
  localparam int RECORD_BYTES = 5;
  localparam int NUM_CFG      = 8;

  // Operation codes
  localparam logic OP_LOG  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Byte select codes within a record
  localparam logic [2:0] BSEL_HOUR   = 3'd0;
  localparam logic [2:0] BSEL_MINUTE = 3'd1;
  localparam logic [2:0] BSEL_SECOND = 3'd2;
  localparam logic [2:0] BSEL_TEMP   = 3'd3;
  localparam logic [2:0] BSEL_LUM    = 3'd4;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MAX_RECORDS     = 3'd0,
    CFG_MONITOR_PERIOD  = 3'd1,
    CFG_ALARM_DURATION  = 3'd2,
    CFG_TEMP_THRESHOLD  = 3'd3,
    CFG_LIGHT_THRESHOLD = 3'd4,
    CFG_ALARM_ENABLE    = 3'd5,
    CFG_CLOCK_HOURS     = 3'd6,
    CFG_CLOCK_MINUTES   = 3'd7
  } cfg_idx_t;

  localparam logic [6:0] MAX_RECORDS_RST = 7'd64;

  // One stored sample
  typedef struct packed {
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
    logic [7:0] temperature;
    logic [7:0] luminosity;
  } rec_t;

  // Configuration bank contents
  typedef struct packed {
    logic [6:0] max_records;
    logic [7:0] monitor_period;
    logic [7:0] alarm_duration;
    logic [7:0] temp_threshold;
    logic [7:0] light_threshold;
    logic [7:0] alarm_enable;
    logic [7:0] clock_hours;
    logic [7:0] clock_minutes;
  } cfg_t;

  // Status part of one result beat (read byte is added later)
  typedef struct packed {
    logic       stored;
    logic [5:0] write_index;
    logic       lapped;
    logic [6:0] unread_count;
    logic       transfer_due;
    logic [7:0] check_byte;
  } res_t;

  // Pick one byte out of a record; unused selector codes give zero
  function automatic logic [7:0] sel_byte(input rec_t r, input logic [2:0] sel);
    logic [7:0] b;
    case (sel)
      BSEL_HOUR:   b = r.hour;
      BSEL_MINUTE: b = r.minute;
      BSEL_SECOND: b = r.second;
      BSEL_TEMP:   b = r.temperature;
      BSEL_LUM:    b = r.luminosity;
      default:     b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/drrl_regs.sv -----
// drrl_regs: configuration register bank and the running sum of its contents.
// Depends on drrl_pkg.
`default_nettype none

module drrl_regs
  import drrl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  output cfg_t            cfg,
  output logic [7:0]      cfg_sum
);

  cfg_t cfg_r;

  // Register writes, one per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{max_records: MAX_RECORDS_RST, default: '0};
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAX_RECORDS:     cfg_r.max_records     <= cfg_wdata[6:0];
        CFG_MONITOR_PERIOD:  cfg_r.monitor_period  <= cfg_wdata;
        CFG_ALARM_DURATION:  cfg_r.alarm_duration  <= cfg_wdata;
        CFG_TEMP_THRESHOLD:  cfg_r.temp_threshold  <= cfg_wdata;
        CFG_LIGHT_THRESHOLD: cfg_r.light_threshold <= cfg_wdata;
        CFG_ALARM_ENABLE:    cfg_r.alarm_enable    <= cfg_wdata;
        CFG_CLOCK_HOURS:     cfg_r.clock_hours     <= cfg_wdata;
        CFG_CLOCK_MINUTES:   cfg_r.clock_minutes   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

  // Modulo-256 sum of the settings (raw max_records)
  assign cfg_sum = 8'({1'b0, cfg_r.max_records}) + cfg_r.monitor_period
                 + cfg_r.alarm_duration + cfg_r.temp_threshold
                 + cfg_r.light_threshold + cfg_r.alarm_enable
                 + cfg_r.clock_hours + cfg_r.clock_minutes;

endmodule

`default_nettype wire

// ----- rtl/drrl_store.sv -----
// drrl_store: record memory, one write port and one registered read port.
// Depends on drrl_pkg for the record type.
`default_nettype none

module drrl_store
  import drrl_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
)(
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(SLOTS)-1:0] wr_addr,
  input  rec_t                          wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(SLOTS)-1:0] rd_addr,
  output rec_t                          rd_data
);

  rec_t mem [SLOTS];
  rec_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/drrl_engine.sv -----
// drrl_engine: write index, lapped flag, duplicate test and result status.
// Depends on drrl_pkg; drives the write port of drrl_store.
`default_nettype none

module drrl_engine
  import drrl_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
)(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     go,
  input  wire logic                     op,
  input  rec_t                          sample,
  input  wire logic [5:0]               read_index,
  input  wire logic [6:0]               max_records,
  input  wire logic [7:0]               cfg_sum,
  output res_t                          res,
  output logic                          wr_en,
  output logic [$clog2(SLOTS)-1:0]      wr_addr
);

  localparam int AW = $clog2(SLOTS);
  localparam int NW = $clog2(SLOTS + 1);
  localparam int CW = (NW > 7) ? NW : 7;
  localparam int UW = CW + 1;

  logic [NW-1:0] next_slot_r, next_slot_nxt;
  logic          wrapped_r, wrapped_nxt;
  logic [7:0]    last_temp_r, last_lum_r;

  logic [NW-1:0] eff_n;
  logic          dup, store, wrap;
  logic [NW-1:0] slot_w;
  logic [UW-1:0] ns_u, rd_u, n_u, sum_u, unread;

  // Clamp max_records to 1..SLOTS
  always_comb begin
    if (max_records == 7'd0) begin
      eff_n = NW'(1);
    end else if (CW'(max_records) > CW'(SLOTS)) begin
      eff_n = NW'(SLOTS);
    end else begin
      eff_n = NW'(max_records);
    end
  end

  // Duplicate test against the last stored record (always at next_slot - 1)
  assign dup   = (next_slot_r != '0) && (sample.temperature == last_temp_r)
              && (sample.luminosity == last_lum_r);
  assign store = (op == OP_LOG) && !dup;
  assign wrap  = (next_slot_r >= eff_n);
  assign slot_w = wrap ? '0 : next_slot_r;

  assign next_slot_nxt = store ? NW'(slot_w + 1'b1) : next_slot_r;
  assign wrapped_nxt   = wrapped_r | (store & wrap);

  // Unread count, wrapped modulo the effective record count, zero past that
  assign ns_u  = UW'(next_slot_nxt);
  assign rd_u  = UW'(read_index);
  assign n_u   = UW'(eff_n);
  assign sum_u = ns_u + n_u;

  always_comb begin
    if (ns_u >= rd_u) begin
      unread = ns_u - rd_u;
    end else if (sum_u >= rd_u) begin
      unread = sum_u - rd_u;
    end else begin
      unread = '0;
    end
  end

  // Result status for this beat
  assign res.stored       = store;
  assign res.write_index  = 6'(next_slot_nxt);
  assign res.lapped       = wrapped_nxt;
  assign res.unread_count = 7'(unread);
  assign res.transfer_due = (unread > (n_u >> 1));
  assign res.check_byte   = cfg_sum + 8'(next_slot_nxt);

  // Memory write
  assign wr_en   = go & store;
  assign wr_addr = AW'(slot_w);

  // Index and lapped flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_slot_r <= '0;
      wrapped_r   <= 1'b0;
    end else if (go) begin
      next_slot_r <= next_slot_nxt;
      wrapped_r   <= wrapped_nxt;
    end
  end

  // Copy of the last stored record's compared bytes
  always_ff @(posedge clk) begin
    if (go && store) begin
      last_temp_r <= sample.temperature;
      last_lum_r  <= sample.luminosity;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dedup_ring_record_logger.sv -----
// Ring record logger: an input beat passes the input register, then the result
// register, to become a result beat; throughput one beat per cycle while the
// output does not stall. Reset (synchronous, active low) clears the write
// index, the lapped flag, both pipeline stages and restores the register
// defaults; the record memory is not cleared.
// Depends on drrl_pkg, drrl_regs, drrl_store and drrl_engine.
`default_nettype none

module dedup_ring_record_logger
  import drrl_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
)(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // configuration write port
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_operation,
  input  wire logic [7:0] in_hour,
  input  wire logic [7:0] in_minute,
  input  wire logic [7:0] in_second,
  input  wire logic [7:0] in_temperature,
  input  wire logic [7:0] in_luminosity,
  input  wire logic [5:0] in_read_index,
  input  wire logic [5:0] in_record_index,
  input  wire logic [2:0] in_byte_select,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_stored,
  output logic [5:0]      out_write_index,
  output logic            out_lapped,
  output logic [6:0]      out_unread_count,
  output logic            out_transfer_due,
  output logic [7:0]      out_check_byte,
  output logic [7:0]      out_read_byte
);

  localparam int AW = $clog2(SLOTS);
  localparam int NW = $clog2(SLOTS + 1);
  localparam int CW = (NW > 7) ? NW : 7;

  cfg_t       cfg;
  logic [7:0] cfg_sum;

  // Input stage
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_op_r;
  rec_t       s1_rec_r;
  logic [5:0] s1_read_index_r, s1_record_index_r;
  logic [2:0] s1_sel_r;

  // Result stage
  logic       s2_valid_r, s2_valid_nxt;
  res_t       s2_res_r;
  logic       s2_rd_ok_r;
  logic [2:0] s2_sel_r;

  logic       in_acc, s1_adv, s2_take, s1_rd_ok;
  res_t       res;
  logic       wr_en;
  logic [AW-1:0] wr_addr;
  rec_t       rd_data;

  drrl_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .cfg_sum   (cfg_sum)
  );

  // Handshake and stage advance
  assign s2_take  = s2_valid_r & !out_stall;
  assign s1_adv   = s1_valid_r & (!s2_valid_r | s2_take);
  assign in_stall = s1_valid_r & !s1_adv;
  assign in_acc   = in_valid & !in_stall;

  assign s1_valid_nxt = in_acc | (s1_valid_r & !s1_adv);
  assign s2_valid_nxt = s1_adv | (s2_valid_r & !s2_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r           <= in_operation;
      s1_rec_r          <= '{hour: in_hour, minute: in_minute, second: in_second,
                             temperature: in_temperature, luminosity: in_luminosity};
      s1_read_index_r   <= in_read_index;
      s1_record_index_r <= in_record_index;
      s1_sel_r          <= in_byte_select;
    end
  end

  drrl_engine #(.SLOTS(SLOTS)) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (s1_adv),
    .op          (s1_op_r),
    .sample      (s1_rec_r),
    .read_index  (s1_read_index_r),
    .max_records (cfg.max_records),
    .cfg_sum     (cfg_sum),
    .res         (res),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr)
  );

  // Read beat is served only for a slot and selector in range
  assign s1_rd_ok = (s1_op_r == OP_READ)
                 && (CW'(s1_record_index_r) < CW'(SLOTS))
                 && (32'(s1_sel_r) < RECORD_BYTES);

  drrl_store #(.SLOTS(SLOTS)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (s1_rec_r),
    .rd_en   (s1_adv & s1_rd_ok),
    .rd_addr (AW'(s1_record_index_r)),
    .rd_data (rd_data)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_res_r   <= res;
      s2_rd_ok_r <= s1_rd_ok;
      s2_sel_r   <= s1_sel_r;
    end
  end

  assign out_valid        = s2_valid_r;
  assign out_stored       = s2_res_r.stored;
  assign out_write_index  = s2_res_r.write_index;
  assign out_lapped       = s2_res_r.lapped;
  assign out_unread_count = s2_res_r.unread_count;
  assign out_transfer_due = s2_res_r.transfer_due;
  assign out_check_byte   = s2_res_r.check_byte;
  assign out_read_byte    = s2_rd_ok_r ? sel_byte(rd_data, s2_sel_r) : 8'd0;

endmodule

`default_nettype wire

// ----- rtl/drrl_checks.sv -----
// drrl_checks: port-level checks on the ring record logger, bound to the top.
// Depends only on the top level's port list.
`default_nettype none

module drrl_checks (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_stored,
  input wire logic [6:0] out_unread_count,
  input wire logic       out_transfer_due,
  input wire logic [7:0] out_read_byte
);

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // Nothing is offered in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat offered straight after reset");

  // A nonzero read byte only comes from a read, which never stores
  a_read_no_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_read_byte != 8'd0) |-> !out_stored)
    else $error("read beat reports a stored record");

  // Transfer-due needs at least one unread record
  a_due_needs_unread: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_unread_count == 7'd0) |-> !out_transfer_due)
    else $error("transfer due with nothing unread");

endmodule

bind dedup_ring_record_logger drrl_checks u_drrl_checks (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_stored       (out_stored),
  .out_unread_count (out_unread_count),
  .out_transfer_due (out_transfer_due),
  .out_read_byte    (out_read_byte)
);

`default_nettype wire

// ----- tb/logger_scoreboard_pkg.sv -----
// Scoreboard for the ring record logger testbench: beat types, a predictor of
// the record store, index and lapped flag, and the checker of result beats.
// Depends on drrl_pkg for the record layout, operation and selector codes.
package logger_scoreboard_pkg;
  import drrl_pkg::*;

  // One input beat as presented on the in_ ports
  typedef struct packed {
    logic       op;
    rec_t       smp;
    logic [5:0] rd_idx;
    logic [5:0] rec_idx;
    logic [2:0] sel;
  } log_item_t;

  // One result beat as seen on the out_ ports
  typedef struct packed {
    logic       stored;
    logic [5:0] write_index;
    logic       lapped;
    logic [6:0] unread;
    logic       due;
    logic [7:0] check;
    logic [7:0] read_byte;
  } log_beat_t;

  class logger_scoreboard;
    rec_t        slot_data [SLOTS_DEF];
    bit          slot_written [SLOTS_DEF];
    int unsigned next_slot;
    bit          wrapped;
    logic [7:0]  regs [NUM_CFG];
    log_beat_t   awaited [$];
    int          fail_count;
    int          beat_count;

    function new();
      next_slot  = 0;
      wrapped    = 1'b0;
      fail_count = 0;
      beat_count = 0;
      foreach (regs[k]) regs[k] = 8'd0;
      foreach (slot_written[k]) slot_written[k] = 1'b0;
      regs[CFG_MAX_RECORDS] = {1'b0, MAX_RECORDS_RST};
    endfunction

    // mirror of one register write; the slot count register is 7 bits wide
    function void set_register(cfg_idx_t idx, logic [7:0] value);
      regs[idx] = (idx == CFG_MAX_RECORDS) ? (value & 8'h7F) : value;
    endfunction

    // slot count actually used for wrapping, clamped to 1..SLOTS
    function int unsigned live_slots();
      int unsigned n;
      n = regs[CFG_MAX_RECORDS];
      if (n < 1) n = 1;
      if (n > SLOTS_DEF) n = SLOTS_DEF;
      return n;
    endfunction

    // work out the result of an accepted input beat and queue it
    function void note_sample(log_item_t it);
      int unsigned n, w, unread, sum;
      bit          dup;
      log_beat_t   b;
      n = live_slots();
      b = '0;
      if (it.op == OP_LOG) begin
        w   = next_slot;
        dup = 1'b0;
        // duplicate test against the record just behind the write index
        if (w != 0)
          dup = (slot_data[w-1].temperature == it.smp.temperature) &&
                (slot_data[w-1].luminosity == it.smp.luminosity);
        if (!dup) begin
          // lazy wrap: index only returns to 0 when the next record lands
          if (w >= n) begin
            w       = 0;
            wrapped = 1'b1;
          end
          slot_data[w]    = it.smp;
          slot_written[w] = 1'b1;
          next_slot       = w + 1;
          b.stored        = 1'b1;
        end
      end else if (it.rec_idx < SLOTS_DEF) begin
        case (it.sel)
          BSEL_HOUR:   b.read_byte = slot_data[it.rec_idx].hour;
          BSEL_MINUTE: b.read_byte = slot_data[it.rec_idx].minute;
          BSEL_SECOND: b.read_byte = slot_data[it.rec_idx].second;
          BSEL_TEMP:   b.read_byte = slot_data[it.rec_idx].temperature;
          BSEL_LUM:    b.read_byte = slot_data[it.rec_idx].luminosity;
          default:     b.read_byte = 8'd0;
        endcase
      end

      // unread count wraps round the live slots, saturates at 0 past that
      if (next_slot >= it.rd_idx)
        unread = next_slot - it.rd_idx;
      else if (next_slot + n >= it.rd_idx)
        unread = next_slot + n - it.rd_idx;
      else
        unread = 0;

      sum = next_slot;
      foreach (regs[k]) sum += regs[k];

      b.write_index = next_slot[5:0];
      b.lapped      = wrapped;
      b.unread      = unread[6:0];
      b.due         = (unread > n / 2);
      b.check       = sum[7:0];
      awaited.push_back(b);
    endfunction

    // one line per mismatch, and count it
    task flag_mismatch(string what, int unsigned got, int unsigned want);
      fail_count++;
      $display("MISMATCH beat %0d: %s got 0x%0h want 0x%0h", beat_count, what, got, want);
    endtask

    // compare one accepted result beat with the oldest prediction
    task check_beat(log_beat_t got);
      log_beat_t want;
      if (awaited.size() == 0) begin
        flag_mismatch("result beat with nothing outstanding", 1, 0);
      end else begin
        want = awaited.pop_front();
        if (got.stored !== want.stored) flag_mismatch("stored", got.stored, want.stored);
        if (got.write_index !== want.write_index)
          flag_mismatch("write_index", got.write_index, want.write_index);
        if (got.lapped !== want.lapped) flag_mismatch("lapped", got.lapped, want.lapped);
        if (got.unread !== want.unread)
          flag_mismatch("unread_count", got.unread, want.unread);
        if (got.due !== want.due) flag_mismatch("transfer_due", got.due, want.due);
        if (got.check !== want.check) flag_mismatch("check_byte", got.check, want.check);
        if (got.read_byte !== want.read_byte)
          flag_mismatch("read_byte", got.read_byte, want.read_byte);
      end
      beat_count++;
    endtask
  endclass

endpackage

// ----- tb/tb_dedup_ring_record_logger.sv -----
// Top of the ring record logger testbench: clock, reset, stimulus, register
// programming, random stalls on both channels and the idle-cycle watchdog.
// Depends on drrl_pkg, logger_scoreboard_pkg and the dedup_ring_record_logger RTL.
module tb_dedup_ring_record_logger;
  timeunit 1ns;
  timeprecision 1ps;
  import drrl_pkg::*;
  import logger_scoreboard_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 135;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_wdata;
  logic in_valid, in_stall, in_operation;
  logic [7:0] in_hour, in_minute, in_second, in_temperature, in_luminosity;
  logic [5:0] in_read_index, in_record_index;
  logic [2:0] in_byte_select;
  logic out_valid, out_stall, out_stored, out_lapped, out_transfer_due;
  logic [5:0] out_write_index;
  logic [6:0] out_unread_count;
  logic [7:0] out_check_byte, out_read_byte;

  logger_scoreboard sb = new();
  bit gaps_on;
  int quiet_cycles;

  dedup_ring_record_logger u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_hour(in_hour), .in_minute(in_minute), .in_second(in_second),
    .in_temperature(in_temperature), .in_luminosity(in_luminosity),
    .in_read_index(in_read_index), .in_record_index(in_record_index),
    .in_byte_select(in_byte_select),
    .out_valid(out_valid), .out_stall(out_stall), .out_stored(out_stored),
    .out_write_index(out_write_index), .out_lapped(out_lapped),
    .out_unread_count(out_unread_count), .out_transfer_due(out_transfer_due),
    .out_check_byte(out_check_byte), .out_read_byte(out_read_byte)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver stalls with a chance of 27 in 100 while gaps are on
  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(0, 99) < 27);
  end

  // accepted input beats feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_sample('{in_operation,
                       '{in_hour, in_minute, in_second, in_temperature, in_luminosity},
                       in_read_index, in_record_index, in_byte_select});
  end

  // accepted result beats are checked
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_beat('{out_stored, out_write_index, out_lapped, out_unread_count,
                      out_transfer_due, out_check_byte, out_read_byte});
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // present one beat after idle cycles, each idle with a chance of 27 in 100,
  // and hold it until taken
  task automatic push_item(input log_item_t it);
    while (gaps_on && ($urandom_range(0, 99) < 27)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= it.op;
    in_hour         <= it.smp.hour;
    in_minute       <= it.smp.minute;
    in_second       <= it.smp.second;
    in_temperature  <= it.smp.temperature;
    in_luminosity   <= it.smp.luminosity;
    in_read_index   <= it.rd_idx;
    in_record_index <= it.rec_idx;
    in_byte_select  <= it.sel;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic push_log(input logic [7:0] h, m, s, t, l, input logic [5:0] rd);
    push_item('{OP_LOG, '{h, m, s, t, l}, rd, 6'($urandom), 3'($urandom)});
  endtask

  task automatic push_read(input logic [5:0] rec, input logic [2:0] sel,
                           input logic [5:0] rd);
    push_item('{OP_READ, rec_t'({$urandom, 8'($urandom)}), rd, rec, sel});
  endtask

  // wait for every outstanding result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // program all eight registers on back-to-back cycles
  task automatic write_bank(input logic [7:0] vals [NUM_CFG]);
    for (int k = 0; k < NUM_CFG; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= k[2:0];
      cfg_wdata <= vals[k];
      @(posedge clk);
      sb.set_register(cfg_idx_t'(k), vals[k]);
    end
    cfg_we <= 1'b0;
  endtask

  // sample byte biased towards the extremes
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    return (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
  endfunction

  // random beat: mostly logs, some repeating the last temperature and light,
  // reads only of slots already written
  function automatic log_item_t random_item();
    log_item_t it;
    int r, rec;
    it.op      = ($urandom_range(0, 99) < 60 || !sb.slot_written[0]) ? OP_LOG : OP_READ;
    it.smp     = '{pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte()};
    it.rec_idx = 6'($urandom);
    it.sel     = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4))
                                              : 3'($urandom_range(5, 7));
    if (it.op == OP_LOG && sb.next_slot != 0 && $urandom_range(0, 3) == 0) begin
      it.smp.temperature = sb.slot_data[sb.next_slot-1].temperature;
      it.smp.luminosity  = sb.slot_data[sb.next_slot-1].luminosity;
    end
    if (it.op == OP_READ) begin
      do rec = $urandom_range(0, SLOTS_DEF - 1); while (!sb.slot_written[rec]);
      it.rec_idx = rec[5:0];
    end
    r = $urandom_range(0, 99);
    if (r < 50)      it.rd_idx = 6'($urandom);
    else if (r < 70) it.rd_idx = 6'(sb.next_slot + $urandom_range(0, 2) - 1);
    else if (r < 85) it.rd_idx = 6'd0;
    else             it.rd_idx = 6'd63;
    return it;
  endfunction

  initial begin
    logic [7:0] bank [NUM_CFG];
    logic [7:0] max_seq [PHASES];
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_operation    = OP_LOG;
    in_hour         = '0;
    in_minute       = '0;
    in_second       = '0;
    in_temperature  = '0;
    in_luminosity   = '0;
    in_read_index   = '0;
    in_record_index = '0;
    in_byte_select  = BSEL_HOUR;
    out_stall       = 1'b0;
    gaps_on         = 1'b1;
    quiet_cycles    = 0;
    max_seq = '{8'd1, 8'd64, 8'd0, 8'd127, 8'd2, 8'd64,
                8'd33, 8'($urandom_range(1, 64)), 8'($urandom), 8'd64};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, duplicate rules, every selector, unread wrap
    push_log(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 6'd0);
    push_log(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'd63);
    push_log(8'h12, 8'h34, 8'h56, 8'hFF, 8'hFF, 6'd1);   // duplicate, dropped
    push_log(8'h01, 8'h02, 8'h03, 8'hFF, 8'h00, 6'd2);   // only temperature repeats
    push_log(8'h04, 8'h05, 8'h06, 8'h01, 8'h00, 6'd3);   // only light repeats
    push_log(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 6'd40);  // unread wraps round
    push_log(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 6'd5);
    for (int s = 0; s < 8; s++)
      push_read(6'd1, 3'(s), (s % 2) ? 6'd63 : 6'd0);
    push_read(6'd0, BSEL_TEMP, 6'd6);
    push_read(6'd5, BSEL_LUM, 6'd32);
    push_read(6'd4, BSEL_MINUTE, 6'd7);
    push_log(8'h00, 8'hFF, 8'h00, 8'hAA, 8'h55, 6'd63); // duplicate of the last record
    drain();

    // random phases, each under its own register settings
    for (int p = 0; p < PHASES; p++) begin
      bank[CFG_MAX_RECORDS] = max_seq[p];
      for (int k = 1; k < NUM_CFG; k++)
        bank[k] = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom);
      write_bank(bank);
      gaps_on = (p != 4);
      for (int i = 0; i < PHASE_ITEMS; i++)
        push_item(random_item());
      drain();
    end

    if (sb.fail_count == 0 && sb.awaited.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/drrl_pkg.sv
rtl/drrl_regs.sv
rtl/drrl_store.sv
rtl/drrl_engine.sv
rtl/dedup_ring_record_logger.sv
rtl/drrl_checks.sv
tb/logger_scoreboard_pkg.sv
tb/tb_dedup_ring_record_logger.sv
